// ===== hdl/bpii_pkg.sv =====
package bpii_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int TABLE_DEPTH = 512;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int WEIGHT_W    = 16;
	localparam int SUM_W       = 36;
	localparam int WIDTH_REG_W = 11;
	localparam int CHAN_W      = 8;
	localparam int BIN_W       = 3;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 40;
	localparam int PADDR_W    = 3;

	localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 11'd640;
	localparam logic [WIDTH_REG_W-1:0] WIDTH_MAX   = WIDTH_REG_W'(MAX_WIDTH);

	localparam logic OP_TABLE = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	localparam logic [PADDR_W-1:0] ADDR_IMAGE_WIDTH = 3'd0;

	// Control that travels with a pixel from the read stage to the update stage.
	typedef struct packed {
		logic             clear;
		logic             first;
		logic             fwd;
		logic [COL_W-1:0] col;
	} s1_ctrl_t;

endpackage

// ===== hdl/bpii_ram.sv =====
module bpii_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/backproject_integral_image_top.sv =====
// Histogram back-projection with an integral image computed on the fly.
// Input stream (s_axis): a transfer with tuser[0] low writes one colour table
// entry; with tuser[0] high it is a pixel, and tuser[1] marks the first pixel
// of a frame. Pixels come in raster order; each yields one output transfer
// (m_axis) carrying the integral-image value in tdata and the mask bit in
// tuser. Table writes yield nothing and may be interleaved with pixels.
// The APB register at address 0 holds the image width (used clamped to 1 to 1024 pixels).
// It takes one item per cycle while the receiver does not stall: the colour
// table and the line store are single-port-read memories with one read and
// one write per cycle, and the line store update of one pixel and the read of
// the next are bridged by a one-entry forwarding register. A pixel passes the
// read stage register and then the output register before m_axis_tvalid rises.
// When the receiver stalls, the result is held in the output
// register, one more pixel may enter the read stage, and then s_axis_tready
// drops until the output is taken. Reset empties the pipeline, sets the
// width to 640 and starts a new frame; the memories are not cleared, so the
// table must be loaded before pixels that use it.
module backproject_integral_image_top import bpii_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// table_index[8:0], table_value[24:9], channel0[32:25], channel1[40:33],
	// channel2[48:41], zero fill
	input  logic [IN_DATA_W-1:0]   s_axis_tdata,
	// op[0], frame_start[1]
	input  logic [1:0]             s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// integral_sum[35:0], zero fill
	output logic [OUT_DATA_W-1:0]  m_axis_tdata,
	// mask_on[0]
	output logic                   m_axis_tuser,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	logic [WIDTH_REG_W-1:0] width_q;
	logic [WIDTH_REG_W-1:0] width_eff;
	logic                   accept;
	logic                   is_pixel;
	logic                   frame_start;
	logic [IDX_W-1:0]       pixel_idx;
	logic [COL_W-1:0]       col_q;
	logic                   first_q;
	logic                   row_start_q;
	logic [COL_W-1:0]       col_cur;
	logic [WIDTH_REG_W-1:0] col_next;
	logic                   valid_s1;
	s1_ctrl_t               ctrl_s1;
	logic                   s1_adv;
	logic [WEIGHT_W-1:0]    weight_rd;
	logic [SUM_W-1:0]       line_rd;
	logic [SUM_W-1:0]       weight_ext;
	logic [SUM_W-1:0]       row_sum;
	logic [SUM_W-1:0]       row_sum_q;
	logic [SUM_W-1:0]       line_val;
	logic [SUM_W-1:0]       total;
	logic [SUM_W-1:0]       last_wr_q;
	logic                   out_valid_q;
	logic [SUM_W-1:0]       out_sum_q;
	logic                   out_mask_q;

	// Configuration port.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_IMAGE_WIDTH) begin
			width_q <= pwdata[WIDTH_REG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_IMAGE_WIDTH) begin
			prdata = {{(32-WIDTH_REG_W){1'b0}}, width_q};
		end
	end

	always_comb begin
		width_eff = width_q;
		if (width_q == '0) begin
			width_eff = WIDTH_REG_W'(1);
		end else if (width_q > WIDTH_MAX) begin
			width_eff = WIDTH_MAX;
		end
	end

	// Input side: table writes complete here, pixels issue their memory reads.
	assign s1_adv        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_adv;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_pixel      = s_axis_tuser[0] == OP_PIXEL;
	assign frame_start   = s_axis_tuser[1];

	// The bin of each channel is its top three bits.
	assign pixel_idx = {s_axis_tdata[32:30], s_axis_tdata[40:38], s_axis_tdata[48:46]};

	always_comb begin
		col_cur = col_q;
		if (frame_start || {1'b0, col_q} >= width_eff) begin
			col_cur = '0;
		end
		col_next = {1'b0, col_cur} + WIDTH_REG_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			first_q     <= 1'b1;
			row_start_q <= 1'b1;
		end else if (accept && is_pixel) begin
			if (col_next >= width_eff) begin
				col_q       <= '0;
				first_q     <= 1'b0;
				row_start_q <= 1'b1;
			end else begin
				col_q       <= col_next[COL_W-1:0];
				first_q     <= first_q || frame_start;
				row_start_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && is_pixel) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// The pixel in the update stage writes the line store at the same edge as
	// this read; when the columns match, the written value is forwarded.
	always_ff @(posedge clk) begin
		if (accept && is_pixel) begin
			ctrl_s1.clear <= frame_start || row_start_q;
			ctrl_s1.first <= frame_start || first_q;
			ctrl_s1.fwd   <= s1_adv && ctrl_s1.col == col_cur;
			ctrl_s1.col   <= col_cur;
		end
	end

	bpii_ram #(
		.WIDTH(WEIGHT_W),
		.DEPTH(TABLE_DEPTH)
	) u_color_table (
		.clk  (clk),
		.we   (accept && !is_pixel),
		.waddr(s_axis_tdata[IDX_W-1:0]),
		.wdata(s_axis_tdata[24:9]),
		.re   (accept && is_pixel),
		.raddr(pixel_idx),
		.rdata(weight_rd)
	);

	bpii_ram #(
		.WIDTH(SUM_W),
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk  (clk),
		.we   (s1_adv),
		.waddr(ctrl_s1.col),
		.wdata(total),
		.re   (accept && is_pixel),
		.raddr(col_cur),
		.rdata(line_rd)
	);

	// Update stage.
	assign weight_ext = {{(SUM_W-WEIGHT_W){weight_rd[WEIGHT_W-1]}}, weight_rd};
	assign row_sum    = (ctrl_s1.clear ? '0 : row_sum_q) + weight_ext;
	assign line_val   = ctrl_s1.fwd ? last_wr_q : line_rd;
	assign total      = ctrl_s1.first ? row_sum : line_val + row_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sum_q <= '0;
		end else if (s1_adv) begin
			row_sum_q <= row_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			last_wr_q  <= total;
			out_sum_q  <= total;
			out_mask_q <= !weight_rd[WEIGHT_W-1] && weight_rd != '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-SUM_W){1'b0}}, out_sum_q};
	assign m_axis_tuser  = out_mask_q;

endmodule

// ===== hdl/bpii_checker.sv =====
module bpii_checker import bpii_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tuser,
	input logic                  psel,
	input logic                  penable,
	input logic                  pwrite,
	input logic [PADDR_W-1:0]    paddr,
	input logic [31:0]           pwdata,
	input logic [31:0]           prdata,
	input logic                  pready
);

	// A stalled result is held unchanged until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output changed while stalled");

	// Once both stages are full and the output stalls, no input is taken.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready && !s_axis_tready) ##1 !m_axis_tready
		|-> !s_axis_tready)
		else $error("input taken while pipeline full and stalled");

	// The padding bits above the sum stay zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:SUM_W] == '0)
		else $error("output padding not zero");

	// A width write is read back at once.
	a_width_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr == ADDR_IMAGE_WIDTH) |=>
		(paddr != ADDR_IMAGE_WIDTH ||
		prdata[WIDTH_REG_W-1:0] == $past(pwdata[WIDTH_REG_W-1:0])))
		else $error("width register readback mismatch");

endmodule

bind backproject_integral_image_top bpii_checker u_bpii_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import bpii_pkg::*;

	// s_axis_tdata layout, lowest field last
	typedef struct packed {
		logic [IN_DATA_W-50:0]      fill;
		logic [CHAN_W-1:0]          chan2;
		logic [CHAN_W-1:0]          chan1;
		logic [CHAN_W-1:0]          chan0;
		logic signed [WEIGHT_W-1:0] weight;
		logic [IDX_W-1:0]           entry;
	} pixel_word_t;

	typedef struct packed {
		logic frame_start;
		logic op;
	} pixel_user_t;

	typedef struct {
		pixel_user_t user;
		pixel_word_t word;
	} stream_item_t;

	typedef struct {
		logic             mask_on;
		logic [SUM_W-1:0] area_sum;
	} area_result_t;

	localparam int RANDOM_ITEMS = 1850;
	localparam int CALM_TAIL    = 200;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// table_index[8:0], table_value[24:9], channel0[32:25], channel1[40:33],
	// channel2[48:41], zero fill
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	// op[0], frame_start[1]
	logic [1:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// integral_sum[35:0], zero fill
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// mask_on[0]
	logic                  m_axis_tuser;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [PADDR_W-1:0]    paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	backproject_integral_image_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shared between the stimulus thread and the bus processes.
	stream_item_t stream_items[$];
	area_result_t pending_sums[$];
	int unsigned  src_idle_pct = 0;
	int unsigned  snk_idle_pct = 0;
	int unsigned  mismatches = 0;
	int unsigned  pixels_checked = 0;
	int unsigned  table_writes_seen = 0;
	int unsigned  width_writes = 0;

	// Predictor state, advanced on every accepted transfer.
	logic signed [WEIGHT_W-1:0] weight_lut [TABLE_DEPTH];
	logic [SUM_W-1:0]           column_sums [MAX_WIDTH];
	logic [SUM_W-1:0]           row_acc = '0;
	int unsigned                col_pos = 0;
	bit                         top_row = 1'b1;
	logic [WIDTH_REG_W-1:0]     width_cfg = WIDTH_RESET;

	// Stimulus-side bookkeeping: which table entries and line columns hold data.
	bit          lut_loaded [TABLE_DEPTH];
	int unsigned gen_col = 0;
	bit          gen_top_row = 1'b1;
	int unsigned gen_cols_written = 0;
	int unsigned gen_width = 32'(WIDTH_RESET);
	int unsigned items_queued = 0;

	function automatic int unsigned clamp_width(input logic [WIDTH_REG_W-1:0] w);
		if (w == 0)
			return 1;
		if (w > WIDTH_MAX)
			return MAX_WIDTH;
		return 32'(w);
	endfunction

	function automatic void backproject_pixel(input pixel_user_t user, input pixel_word_t word);
		logic signed [WEIGHT_W-1:0] wt;
		logic [SUM_W-1:0]           wide;
		logic [SUM_W-1:0]           total;
		int unsigned                c;
		int unsigned                eff;
		area_result_t               res;
		if (user.op == OP_TABLE) begin
			weight_lut[word.entry] = word.weight;
			table_writes_seen++;
			return;
		end
		if (user.frame_start) begin
			col_pos = 0;
			row_acc = '0;
			top_row = 1'b1;
		end
		wt = weight_lut[{word.chan0[7:5], word.chan1[7:5], word.chan2[7:5]}];
		wide = {{(SUM_W-WEIGHT_W){wt[WEIGHT_W-1]}}, wt};
		eff = clamp_width(width_cfg);
		c = (col_pos >= eff) ? 0 : col_pos;
		row_acc = row_acc + wide;
		total = top_row ? row_acc : column_sums[c] + row_acc;
		column_sums[c] = total;
		res.mask_on = (wt > 0);
		res.area_sum = total;
		pending_sums.push_back(res);
		c++;
		if (c >= eff) begin
			col_pos = 0;
			row_acc = '0;
			top_row = 1'b0;
		end else begin
			col_pos = c;
		end
	endfunction

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		logic [WEIGHT_W-1:0] corners [5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF};
		if ($urandom_range(0, 7) == 0)
			return corners[$urandom_range(0, 4)];
		return WEIGHT_W'($urandom());
	endfunction

	function automatic void queue_table_write(input logic [IDX_W-1:0] entry,
			input logic [WEIGHT_W-1:0] wt);
		stream_item_t it;
		it.user.op = OP_TABLE;
		it.user.frame_start = 1'($urandom_range(0, 1));
		it.word = IN_DATA_W'({$urandom(), $urandom()});
		it.word.chan1 = CHAN_W'($urandom());
		it.word.chan2 = CHAN_W'($urandom());
		it.word.fill = '0;
		it.word.entry = entry;
		it.word.weight = wt;
		lut_loaded[entry] = 1'b1;
		stream_items.push_back(it);
		items_queued++;
	endfunction

	// A pixel that would read a line column never written starts a new frame instead.
	function automatic void queue_pixel(input bit fs, input logic [7:0] b, input logic [7:0] g,
			input logic [7:0] r);
		logic [IDX_W-1:0] entry;
		int unsigned      c;
		stream_item_t     it;
		entry = {b[7:5], g[7:5], r[7:5]};
		if (!lut_loaded[entry])
			queue_table_write(entry, pick_weight());
		if (!fs && !gen_top_row) begin
			c = (gen_col >= gen_width) ? 0 : gen_col;
			if (c >= gen_cols_written)
				fs = 1'b1;
		end
		if (fs) begin
			gen_col = 0;
			gen_top_row = 1'b1;
		end
		c = (gen_col >= gen_width) ? 0 : gen_col;
		if (c + 1 > gen_cols_written)
			gen_cols_written = c + 1;
		c++;
		if (c >= gen_width) begin
			gen_col = 0;
			gen_top_row = 1'b0;
		end else begin
			gen_col = c;
		end
		it.user.op = OP_PIXEL;
		it.user.frame_start = fs;
		it.word.fill = '0;
		it.word.entry = IDX_W'($urandom());
		it.word.weight = WEIGHT_W'($urandom());
		it.word.chan0 = b;
		it.word.chan1 = g;
		it.word.chan2 = r;
		stream_items.push_back(it);
		items_queued++;
	endfunction

	// Input driver: a new item goes out only once the previous one has been taken.
	stream_item_t drv_item;
	bit           in_took = 1'b0;
	int unsigned  src_gap = 0;

	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_took)) begin
			if (src_gap != 0) begin
				src_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
				src_gap = $urandom_range(0, 12);
				s_axis_tvalid <= 1'b0;
			end else if (stream_items.size() != 0) begin
				drv_item = stream_items.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= drv_item.word;
				s_axis_tuser <= drv_item.user;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure.
	int unsigned snk_gap = 0;

	always @(negedge clk) begin
		if (snk_gap != 0) begin
			snk_gap--;
			m_axis_tready <= 1'b0;
		end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
			snk_gap = $urandom_range(0, 12);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Monitor: predicts on each accepted input transfer and checks each output transfer.
	area_result_t got_exp;

	always @(posedge clk) begin
		in_took <= s_axis_tvalid && s_axis_tready;
		if (psel && penable && pready && paddr == ADDR_IMAGE_WIDTH) begin
			if (pwrite) begin
				width_cfg = pwdata[WIDTH_REG_W-1:0];
				width_writes++;
			end else if (prdata !== {{(32-WIDTH_REG_W){1'b0}}, width_cfg}) begin
				mismatches++;
				$display("%0t: image_width read expected %0d, got %0d", $time, width_cfg,
					prdata);
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready)
			backproject_pixel(pixel_user_t'(s_axis_tuser), pixel_word_t'(s_axis_tdata));
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_sums.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected output transfer, sum %0h mask %0b", $time,
					m_axis_tdata[SUM_W-1:0], m_axis_tuser);
			end else begin
				got_exp = pending_sums.pop_front();
				pixels_checked++;
				if (m_axis_tuser !== got_exp.mask_on) begin
					mismatches++;
					$display("%0t: mask_on expected %0b, got %0b", $time, got_exp.mask_on,
						m_axis_tuser);
				end
				if (m_axis_tdata[SUM_W-1:0] !== got_exp.area_sum) begin
					mismatches++;
					$display("%0t: integral_sum expected %0h, got %0h", $time,
						got_exp.area_sum, m_axis_tdata[SUM_W-1:0]);
				end
			end
		end
	end

	task automatic apb_access(input bit wr, input logic [31:0] wdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_IMAGE_WIDTH;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Table writes leave nothing to wait for, so the wait goes on past the last result.
	task automatic wait_drained();
		@(negedge clk);
		while (stream_items.size() != 0 || s_axis_tvalid || pending_sums.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int unsigned corner_widths [8] = '{1, 0, 2047, 3, 1024, 2, 1025, 5};
		int unsigned idle_choices [3] = '{0, 8, 25};
		int unsigned phase;
		int unsigned wval;
		int unsigned n;
		int unsigned base;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		apb_access(1'b0, '0);

		// Directed: weight extremes, bin boundaries, frame start mid-row, ignored fields.
		@(posedge clk);
		queue_table_write(9'd0, 16'h7FFF);
		queue_table_write(9'd511, 16'h8000);
		queue_table_write(9'd73, 16'h0000);
		queue_table_write(9'd146, 16'h0001);
		queue_table_write(9'd219, 16'hFFFF);
		queue_pixel(1'b1, 8'd0, 8'd0, 8'd0);
		queue_pixel(1'b0, 8'd255, 8'd255, 8'd255);
		queue_pixel(1'b0, 8'd31, 8'd31, 8'd31);
		queue_pixel(1'b0, 8'd32, 8'd32, 8'd32);
		queue_pixel(1'b0, 8'd95, 8'd95, 8'd95);
		queue_pixel(1'b0, 8'd96, 8'd96, 8'd96);
		queue_pixel(1'b0, 8'd224, 8'd224, 8'd224);
		queue_table_write(9'd0, 16'h8001);
		queue_pixel(1'b1, 8'd7, 8'd0, 8'd31);
		queue_pixel(1'b0, 8'd255, 8'd224, 8'd255);
		queue_pixel(1'b0, 8'd128, 8'd64, 8'd160);
		wait_drained();

		items_queued = 0;
		phase = 0;
		while (items_queued < RANDOM_ITEMS) begin
			if (phase < 8)
				wval = corner_widths[phase];
			else if ($urandom_range(0, 9) < 7)
				wval = $urandom_range(1, 12);
			else if ($urandom_range(0, 1) == 0)
				wval = $urandom_range(13, 64);
			else
				wval = $urandom_range(0, 2047);
			apb_access(1'b1, wval);
			apb_access(1'b0, '0);
			gen_width = clamp_width(WIDTH_REG_W'(wval));
			if (items_queued + CALM_TAIL >= RANDOM_ITEMS) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end else begin
				src_idle_pct = idle_choices[$urandom_range(0, 2)];
				snk_idle_pct = idle_choices[$urandom_range(0, 2)];
			end
			n = (gen_width <= 64) ? $urandom_range(60, 140) : $urandom_range(20, 60);
			base = items_queued;
			@(posedge clk);
			while (items_queued - base < n) begin
				if ($urandom_range(0, 99) < 15)
					queue_table_write(IDX_W'($urandom()), pick_weight());
				else
					queue_pixel($urandom_range(0, 99) < 2, CHAN_W'($urandom()),
						CHAN_W'($urandom()), CHAN_W'($urandom()));
			end
			wait_drained();
			phase++;
		end

		repeat (20) @(negedge clk);
		$display("Checked %0d pixels against %0d colour table writes across %0d width settings,",
			pixels_checked, table_writes_seen, width_writes);
		$display("including widths 0, 1, 1024, 1025 and 2047 and mid-frame width changes.");
		if (mismatches == 0 && pending_sums.size() == 0) begin
			$display("backproject_integral_image_top regression: pass");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches,
				pending_sums.size());
			$display("backproject_integral_image_top regression: fail");
		end
		$finish;
	end

	initial begin
		#1_500_000;
		$display("Timed out with %0d results outstanding", pending_sums.size());
		$display("backproject_integral_image_top regression: fail");
		$finish;
	end

endmodule
